// ===== hdl/nge_pkg.sv =====
// Shared types and constants of the noise gate envelope unit.
package nge_pkg;

  // Width of the configuration data port and of the wide registers
  localparam int CFG_W      = 25;
  // Width of the hold length register
  localparam int HOLD_CFG_W = 20;
  // Width of the register index
  localparam int CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0]      THRESHOLD_RST = 25'd2653;
  localparam logic [CFG_W-1:0]      ATTACK_RST    = 25'd87381;
  localparam logic [CFG_W-1:0]      DECAY_RST     = 25'd6991;
  localparam logic [HOLD_CFG_W-1:0] HOLD_RST      = 20'd240;
  localparam logic [CFG_W-1:0]      FLOOR_RST     = 25'd530542;

  // Gate phase codes, as seen on the gate_phase output
  typedef enum logic [1:0] {
    PH_CLOSED = 2'd0,
    PH_ATTACK = 2'd1,
    PH_OPEN   = 2'd2,
    PH_DECAY  = 2'd3
  } gate_phase_t;

endpackage

// ===== hdl/noise_gate_envelope_unit.sv =====
// Noise gate with attack, hold and decay envelope, built round one shared multiplier.
// Each accepted item runs S_UPDATE, S_MUL_FLOOR, S_GAIN, S_MUL_SAMPLE, then S_DONE sets
// out_valid once the output register holds no untaken earlier result. A new item is taken
// only in S_IDLE, after the last is passed on; the multiplier is used twice per item.
// Reset: rst (synchronous) closes the gate, clears level and hold count, empties the
// output register and loads the register defaults.
module noise_gate_envelope_unit
  import nge_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 24,
  parameter int HOLD_BITS      = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic [1:0]                    gate_phase,
  input  logic                          cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam int LW = ((GW > CFG_W) ? GW : CFG_W) + 1;
  localparam int MW = (SAMPLE_BITS > GW) ? SAMPLE_BITS : GW;
  localparam int PW = 2 * MW;
  localparam int CW = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

  localparam logic [GW-1:0] ONE_G = GW'(1) << GAIN_FRAC_BITS;
  localparam logic [LW-1:0] ONE_L = LW'(1) << GAIN_FRAC_BITS;
  localparam logic [PW-1:0] RND   = (PW'(1) << GAIN_FRAC_BITS) - PW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_MUL_FLOOR,
    S_GAIN,
    S_MUL_SAMPLE,
    S_DONE
  } seq_t;

  seq_t                   seq;
  logic [CFG_W-1:0]       threshold_level;
  logic [CFG_W-1:0]       attack_step;
  logic [CFG_W-1:0]       decay_step;
  logic [HOLD_CFG_W-1:0]  hold_samples;
  logic [CFG_W-1:0]       floor_gain;

  gate_phase_t            phase, phase_next;
  logic [GW-1:0]          level, level_next;
  logic [HOLD_BITS-1:0]   hold_count, hold_count_next;

  logic [SAMPLE_BITS-1:0] mag;
  logic                   neg;
  logic                   loud;
  logic [GW-1:0]          gain;
  logic [PW-1:0]          prod;

  logic [SAMPLE_BITS-1:0] in_mag;
  logic                   in_loud;
  logic [LW-1:0]          level_ext, attack_sum, decay_ext;
  logic [GW-1:0]          floor_clamped;
  logic [GW-1:0]          gain_calc;
  logic [MW-1:0]          mul_a, mul_b;
  logic [PW-1:0]          mul_out;
  logic [PW-1:0]          q_pos, q_neg;
  logic                   out_free;

  assign in_ready = (seq == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Magnitude of the incoming sample; the most negative code maps to 2^(SAMPLE_BITS-1)
  assign in_mag  = sample_in[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(sample_in))
                                            : SAMPLE_BITS'(sample_in);
  assign in_loud = CW'(in_mag) >= CW'(threshold_level);

  assign floor_clamped = (LW'(floor_gain) > ONE_L) ? ONE_G : GW'(floor_gain);

  // Envelope update
  assign level_ext  = LW'(level);
  assign attack_sum = level_ext + LW'(attack_step);
  assign decay_ext  = LW'(decay_step);

  always_comb begin
    phase_next      = phase;
    level_next      = level;
    hold_count_next = hold_count;
    case (phase)
      PH_CLOSED: begin
        if (loud) phase_next = PH_ATTACK;
      end
      PH_ATTACK: begin
        if (attack_sum >= ONE_L) begin
          level_next      = ONE_G;
          phase_next      = PH_OPEN;
          hold_count_next = HOLD_BITS'(hold_samples);
        end else begin
          level_next = GW'(attack_sum);
        end
      end
      PH_OPEN: begin
        if (hold_count == '0) begin
          if (!loud) phase_next = PH_DECAY;
        end else begin
          hold_count_next = hold_count - HOLD_BITS'(1);
        end
      end
      PH_DECAY: begin
        if (level_ext > decay_ext) level_next = GW'(level_ext - decay_ext);
        else level_next = '0;
        if (loud) phase_next = PH_ATTACK;
        else if (level_next == '0) phase_next = PH_CLOSED;
      end
      default: begin
        phase_next = PH_CLOSED;
      end
    endcase
  end

  // Shared multiplier: floor times headroom, then magnitude times gain
  always_comb begin
    case (seq)
      S_MUL_FLOOR: begin
        mul_a = MW'(floor_clamped);
        mul_b = MW'(ONE_G - level);
      end
      default: begin
        mul_a = MW'(mag);
        mul_b = MW'(gain);
      end
    endcase
  end

  assign mul_out = PW'(mul_a) * PW'(mul_b);

  assign gain_calc = (level == '0) ? floor_clamped
                                   : level + GW'(prod >> GAIN_FRAC_BITS);

  // Truncate toward minus infinity on both signs
  assign q_pos = prod >> GAIN_FRAC_BITS;
  assign q_neg = (prod + RND) >> GAIN_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq             <= S_IDLE;
      threshold_level <= THRESHOLD_RST;
      attack_step     <= ATTACK_RST;
      decay_step      <= DECAY_RST;
      hold_samples    <= HOLD_RST;
      floor_gain      <= FLOOR_RST;
      phase           <= PH_CLOSED;
      level           <= '0;
      hold_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_THRESHOLD: threshold_level <= cfg_data;
          CFG_ATTACK:    attack_step     <= cfg_data;
          CFG_DECAY:     decay_step      <= cfg_data;
          CFG_HOLD:      hold_samples    <= cfg_data[HOLD_CFG_W-1:0];
          CFG_FLOOR:     floor_gain      <= cfg_data;
          default: ;
        endcase
      end

      // Drop the result once taken, unless a new one replaces it this cycle
      if (out_valid && out_ready && seq != S_DONE) out_valid <= 1'b0;

      case (seq)
        S_IDLE: begin
          if (in_valid) begin
            mag  <= in_mag;
            neg  <= sample_in[SAMPLE_BITS-1];
            loud <= in_loud;
            seq  <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          phase      <= phase_next;
          level      <= level_next;
          hold_count <= hold_count_next;
          seq        <= S_MUL_FLOOR;
        end
        S_MUL_FLOOR: begin
          prod <= mul_out;
          seq  <= S_GAIN;
        end
        S_GAIN: begin
          gain <= gain_calc;
          seq  <= S_MUL_SAMPLE;
        end
        S_MUL_SAMPLE: begin
          prod <= mul_out;
          seq  <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (out_free) begin
            sample_out <= neg ? SAMPLE_BITS'(PW'(0) - q_neg) : SAMPLE_BITS'(q_pos);
            gate_phase <= phase;
            out_valid  <= 1'b1;
            seq        <= S_IDLE;
          end
        end
        default: begin
          seq <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the noise gate envelope unit: phases, level, hold and gated samples.
module testbench
  import nge_pkg::*;
();

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 24;
  localparam logic [63:0] UNITY = 64'd1 << GAIN_FRAC_BITS;
  localparam logic [63:0] SAMPLE_SPAN = 64'd1 << SAMPLE_BITS;
  localparam logic [CFG_W-1:0] FULL_SCALE = 25'h800000;
  localparam logic [CFG_W-1:0] CFG_ALL_ONES = 25'h1FFFFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int STALL_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t     sample;
    gate_phase_t phase;
  } gated_t;

  class gate_tracker;
    logic [CFG_W-1:0]      threshold;
    logic [CFG_W-1:0]      attack_step;
    logic [CFG_W-1:0]      decay_step;
    logic [CFG_W-1:0]      floor_gain;
    logic [HOLD_CFG_W-1:0] hold_len;
    gate_phase_t           phase;
    logic [63:0]           level;
    logic [HOLD_CFG_W-1:0] hold_left;
    gated_t                pending_gated[$];
    int                    mismatches;
    int                    results_seen;
    int                    phase_hits[4];

    function new();
      threshold    = THRESHOLD_RST;
      attack_step  = ATTACK_RST;
      decay_step   = DECAY_RST;
      hold_len     = HOLD_RST;
      floor_gain   = FLOOR_RST;
      phase        = PH_CLOSED;
      level        = '0;
      hold_left    = '0;
      mismatches   = 0;
      results_seen = 0;
      foreach (phase_hits[i]) phase_hits[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_THRESHOLD: threshold = value;
        CFG_ATTACK:    attack_step = value;
        CFG_DECAY:     decay_step = value;
        CFG_HOLD:      hold_len = value[HOLD_CFG_W-1:0];
        CFG_FLOOR:     floor_gain = value;
        default: ;
      endcase
    endfunction

    // Advance the envelope by one sample and queue the gated result
    function void note_sample(sample_t s);
      logic [63:0] raw, mag, fl, g, prod, q, signed_q;
      logic        neg, loud;
      gated_t      e;
      raw = '0;
      raw[SAMPLE_BITS-1:0] = s;
      neg = s[SAMPLE_BITS-1];
      mag = neg ? SAMPLE_SPAN - raw : raw;
      loud = (mag >= threshold);
      case (phase)
        PH_CLOSED: begin
          if (loud) phase = PH_ATTACK;
        end
        PH_ATTACK: begin
          level = level + attack_step;
          if (level >= UNITY) begin
            level = UNITY;
            phase = PH_OPEN;
            hold_left = hold_len;
          end
        end
        PH_OPEN: begin
          if (hold_left == 0) begin
            if (!loud) phase = PH_DECAY;
          end else begin
            hold_left = hold_left - 1'b1;
          end
        end
        default: begin
          level = (level > decay_step) ? level - decay_step : 64'd0;
          if (loud) phase = PH_ATTACK;
          else if (level == 0) phase = PH_CLOSED;
        end
      endcase
      fl = (floor_gain > UNITY) ? UNITY : 64'(floor_gain);
      g = (level == 0) ? fl : level + ((fl * (UNITY - level)) >> GAIN_FRAC_BITS);
      prod = mag * g;
      // round the magnitude up for negative samples so the result floors
      q = neg ? (prod + UNITY - 1) >> GAIN_FRAC_BITS : prod >> GAIN_FRAC_BITS;
      signed_q = neg ? 64'd0 - q : q;
      e.sample = signed_q[SAMPLE_BITS-1:0];
      e.phase = phase;
      pending_gated.push_back(e);
    endfunction

    function void check_result(sample_t got_sample, logic [1:0] got_phase);
      gated_t e;
      results_seen++;
      if (pending_gated.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d not expected: sample %0d phase %0d",
                   results_seen, got_sample, got_phase);
        return;
      end
      e = pending_gated.pop_front();
      phase_hits[e.phase]++;
      if (got_sample !== e.sample || got_phase !== e.phase) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d: expected sample %0d phase %0d, got sample %0d phase %0d",
                   results_seen, e.sample, e.phase, got_sample, got_phase);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sample_t              sample_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sample_t              sample_out;
  logic [1:0]           gate_phase;
  logic                 cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  gate_tracker tracker = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  stall_request = 1'b0;
  int  burst_left = 0;
  bit  burst_loud = 1'b0;
  int  quiet_cycles = 0;

  noise_gate_envelope_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .sample_in        (sample_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .sample_out       (sample_out),
    .gate_phase       (gate_phase),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Write one register once the block has handed back every result
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (tracker.pending_gated.size() != 0) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    tracker.set_reg(idx, value);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_gate(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] att,
                              logic [CFG_W-1:0] dec, logic [CFG_W-1:0] hold,
                              logic [CFG_W-1:0] flr);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_ATTACK, att);
    write_reg(CFG_DECAY, dec);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_FLOOR, flr);
  endtask

  task automatic send_sample(sample_t s);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    tracker.note_sample(s);
  endtask

  function automatic sample_t shaped_sample(bit loud, logic [CFG_W-1:0] thr);
    logic [CFG_W-1:0] mag;
    sample_t          s;
    if (loud && thr <= FULL_SCALE)
      mag = CFG_W'($urandom_range(FULL_SCALE, thr));
    else if (!loud && thr != 0)
      mag = CFG_W'($urandom_range((thr > FULL_SCALE) ? FULL_SCALE : thr - 1'b1, 0));
    else
      mag = CFG_W'($urandom_range(FULL_SCALE, 0));
    // full scale magnitude only exists as the most negative sample
    if (mag == FULL_SCALE) s = sample_t'(FULL_SCALE);
    else if ($urandom_range(1, 0) == 1) s = -sample_t'(mag);
    else s = sample_t'(mag);
    return s;
  endfunction

  // Alternate loud and quiet bursts, with some extremes and raw noise mixed in
  task automatic run_random(int count);
    int      roll;
    sample_t s;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_loud = !burst_loud;
        burst_left = $urandom_range(24, 1);
      end
      burst_left--;
      roll = $urandom_range(19, 0);
      if (roll == 0) begin
        case ($urandom_range(4, 0))
          0: s = '0;
          1: s = -sample_t'(1);
          2: s = sample_t'(1);
          3: s = sample_t'(FULL_SCALE - 1'b1);
          default: s = sample_t'(FULL_SCALE);
        endcase
      end else if (roll == 1) begin
        s = sample_t'($urandom);
      end else begin
        s = shaped_sample(burst_loud, tracker.threshold);
      end
      send_sample(s);
    end
  endtask

  // Receiver side: take results and pace out_ready
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) tracker.check_result(sample_out, gate_phase);
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sample_t directed_run[$];
    directed_run = '{24'sd0, 24'sd4095, -24'sd4095, 24'sd4096, 24'sh800000,
                     24'sh7FFFFF, -24'sd1, 24'sd1, 24'sd3, -24'sd4096, 24'sd100,
                     24'sd200, 24'sd5000, 24'sd5000, -24'sd4096, -24'sd4095,
                     24'sd1, -24'sd1, 24'sh800000, 24'sd0, 24'sd0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 11;
    recv_idle_pct = 52;
    // register defaults straight out of reset
    run_random(200);

    // short steps so that every phase is passed within a few samples
    write_reg(CFG_THRESHOLD, 25'd4096);
    write_reg(CFG_ATTACK, 25'h800000);
    write_reg(CFG_DECAY, 25'h800000);
    write_reg(CFG_HOLD, 25'd1);
    write_reg(CFG_FLOOR, 25'd0);
    while (tracker.phase != PH_CLOSED) send_sample('0);
    foreach (directed_run[i]) send_sample(directed_run[i]);

    // everything loud, full attack in one step, floor above unity
    program_gate(25'd0, 25'h1000000, 25'd1, 25'd0, CFG_ALL_ONES);
    run_random(60);

    send_idle_pct = 52;
    recv_idle_pct = 11;
    // nothing loud and no decay step: the gate sticks in decay
    program_gate(CFG_ALL_ONES, 25'd0, 25'd0, CFG_ALL_ONES, 25'h1000000);
    run_random(30);
    // no attack step: once attack starts from zero the level never rises
    program_gate(25'h100000, 25'd0, 25'h1000000, 25'd5, CFG_ALL_ONES);
    run_random(40);
    program_gate(25'h40000, 25'h400000, 25'h200000, 25'd3, 25'd0);
    run_random(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // only the most negative sample reaches the threshold
    program_gate(FULL_SCALE, 25'h1000000, 25'h300000, 25'd1, 25'h123456);
    for (int i = CFG_SPARE_LO; i <= CFG_SPARE_HI; i++)
      write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
    run_random(100);

    for (int k = 0; k < 2; k++) begin
      program_gate(CFG_W'($urandom_range(1 << 22, 0)), CFG_W'($urandom_range(1 << 24, 1)),
                   CFG_W'($urandom_range(1 << 22, 1)), CFG_W'($urandom_range(7, 0)),
                   CFG_W'($urandom_range(CFG_ALL_ONES, 0)));
      // hold the output back while samples keep coming, so the input stalls
      if (k == 0) stall_request = 1'b1;
      run_random(75);
    end

    in_valid <= 1'b0;
    while (tracker.pending_gated.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d gated samples over nine register settings and one %0d-cycle stall",
             tracker.results_seen, STALL_CYCLES);
    $display("Results by phase: closed %0d, attack %0d, open %0d, decay %0d",
             tracker.phase_hits[PH_CLOSED], tracker.phase_hits[PH_ATTACK],
             tracker.phase_hits[PH_OPEN], tracker.phase_hits[PH_DECAY]);
    if (tracker.mismatches == 0 && tracker.pending_gated.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/nge_pkg.sv
hdl/noise_gate_envelope_unit.sv
bench/testbench.sv
